FILE: src/gwm_pkg.sv
`timescale 1ns / 1ps
package gwm_pkg;

  // Pattern capacity and derived widths
  localparam int MAX_PATTERN = 64;
  localparam int POS_W       = MAX_PATTERN + 1;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // Wildcard bytes
  localparam logic [7:0] CH_STAR  = 8'd42;
  localparam logic [7:0] CH_QUEST = 8'd63;

  typedef enum logic [1:0] {
    REQ_NEW    = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_SUBJ   = 2'd2,
    REQ_END    = 2'd3
  } req_type_t;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    req_type_t  req;
    logic [7:0] ch;
  } item_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } res_t;

  // Close an active set over runs of stars: position q is reached when q-1 is
  // reached and holds a star. Log-depth prefix scan, carry lookahead style.
  function automatic pos_t star_scan(pos_t seed, pos_t prop);
    pos_t g;
    pos_t p;
    pos_t g_n;
    pos_t p_n;
    g = seed;
    p = prop;
    for (int d = 1; d < POS_W; d = d * 2) begin
      g_n = g;
      p_n = p;
      for (int i = d; i < POS_W; i++) begin
        g_n[i] = g[i] | (p[i] & g[i-d]);
        p_n[i] = p[i] & p[i-d];
      end
      g = g_n;
      p = p_n;
    end
    return g;
  endfunction

endpackage

FILE: src/gwm_in_stage.sv
`timescale 1ns / 1ps
module gwm_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_tready,
  input  logic [1:0]    in_tuser,
  input  logic [7:0]    in_tdata,
  input  logic          fire,
  output logic          item_v,
  output gwm_pkg::item_t item
);
  import gwm_pkg::*;

  logic  item_v_r;
  item_t item_r;

  // Hold the accepted word until the core takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      item_v_r <= 1'b1;
    end else if (fire) begin
      item_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.req <= req_type_t'(in_tuser);
      item_r.ch  <= in_tdata;
    end
  end

  assign item_v = item_v_r;
  assign item   = item_r;

endmodule

FILE: src/gwm_core.sv
`timescale 1ns / 1ps
module gwm_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  gwm_pkg::item_t item,
  output logic           res_v,
  output gwm_pkg::res_t  res
);
  import gwm_pkg::*;

  logic [7:0]       pat_r [MAX_PATTERN];
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] len_nxt;
  logic             ovf_r;
  logic             ovf_nxt;
  pos_t             act_r;
  pos_t             act_nxt;

  logic [MAX_PATTERN-1:0] vmask;
  logic [MAX_PATTERN-1:0] star;
  logic [MAX_PATTERN-1:0] hit;
  logic [MAX_PATTERN-1:0] star_app;
  logic                   room;
  pos_t                   step;
  pos_t                   seed0;
  pos_t                   upto_len;

  assign room  = (len_r < LEN_W'(MAX_PATTERN));
  assign seed0 = POS_W'(1);

  // Decode stored positions: valid, star, and byte match for the current word
  always_comb begin
    for (int p = 0; p < MAX_PATTERN; p++) begin
      vmask[p]    = (LEN_W'(p) < len_r);
      star[p]     = vmask[p] && (pat_r[p] == CH_STAR);
      hit[p]      = vmask[p] && !star[p] &&
                    ((pat_r[p] == CH_QUEST) || (pat_r[p] == item.ch));
      // star flags as they stand once the appended byte is written
      star_app[p] = star[p] ||
                    (room && (LEN_W'(p) == len_r) && (item.ch == CH_STAR));
    end
    for (int q = 0; q < POS_W; q++) begin
      upto_len[q] = (LEN_W'(q) <= len_r);
    end
  end

  // Advance the active set by one subject byte
  always_comb begin
    step = '0;
    for (int p = 0; p < MAX_PATTERN; p++) begin
      step[p]   = step[p]   | (act_r[p] & star[p]);
      step[p+1] = act_r[p] & hit[p];
    end
  end

  // Next state per request kind
  always_comb begin
    len_nxt = len_r;
    ovf_nxt = ovf_r;
    act_nxt = act_r;
    if (fire) begin
      unique case (item.req)
        REQ_NEW: begin
          len_nxt = '0;
          ovf_nxt = 1'b0;
          act_nxt = seed0;
        end
        REQ_APPEND: begin
          if (room) begin
            len_nxt = len_r + LEN_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          act_nxt = star_scan(seed0, {star_app, 1'b0});
        end
        REQ_SUBJ: begin
          act_nxt = star_scan(step, {star, 1'b0});
        end
        REQ_END: begin
          act_nxt = star_scan(seed0, {star, 1'b0});
        end
        default: begin
          act_nxt = act_r;
        end
      endcase
    end
  end

  // Result on an end word
  assign res_v            = fire && (item.req == REQ_END);
  assign res.matched      = act_r[len_r] && !ovf_r;
  assign res.pattern_overflow = ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ovf_r <= 1'b0;
      act_r <= seed0;
    end else begin
      len_r <= len_nxt;
      ovf_r <= ovf_nxt;
      act_r <= act_nxt;
    end
  end

  // Write an appended byte while there is room
  always_ff @(posedge clk) begin
    if (fire && (item.req == REQ_APPEND) && room) begin
      pat_r[len_r[IDX_W-1:0]] <= item.ch;
    end
  end

  // No position past the pattern end is ever reached
  a_act_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (act_r & ~upto_len) == '0)
    else $error("active position beyond pattern length");

  // Overflow only once the store is full
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (len_r == LEN_W'(MAX_PATTERN)))
    else $error("overflow flagged with room left");

  // A new pattern leaves an empty pattern armed at position zero
  a_new_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.req == REQ_NEW) |=> (len_r == '0 && !ovf_r && act_r == seed0))
    else $error("new pattern did not clear state");

  // A subject byte never sets the flag or moves the length
  a_subj_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.req == REQ_SUBJ) |=> ($stable(len_r) && $stable(ovf_r)))
    else $error("subject byte changed pattern state");

endmodule

FILE: src/gwm_out_stage.sv
`timescale 1ns / 1ps
module gwm_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_v,
  input  gwm_pkg::res_t res,
  input  logic          out_tready,
  output logic          out_tvalid,
  output logic [7:0]    out_tdata
);
  import gwm_pkg::*;

  logic valid_r;
  res_t res_r;

  // Load a new result, drop the held one once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_v) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_v) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {6'd0, res_r.pattern_overflow, res_r.matched};

endmodule

FILE: src/glob_wildcard_matcher.sv
`timescale 1ns / 1ps
// Glob matcher for '*' and '?' over a byte stream.
// Input channel: in_tuser selects the request (new pattern, append pattern
// byte, subject byte, end of subject) and in_tdata carries the byte. A
// pattern is built byte by byte, then a subject streams one byte per word;
// the end word produces one result word on the output channel with the
// match bit and the pattern overflow flag. Other requests produce nothing.
// Throughput: one input word per clock cycle while no end word waits on a
// held result, set by the single registered pass of the core that updates
// every pattern position at once. Result path: an end word accepted into
// the input register is evaluated by the core once it can advance, and its
// result is registered in the output stage and then shown on out_tvalid.
// Reset (rst_n low, synchronous) leaves an empty pattern with no overflow;
// an empty subject then matches.
// When the receiver stalls, the result is held; pattern and subject words
// keep flowing, and a further end word waits in the input register until
// the held result has been taken.
module glob_wildcard_matcher (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] ch
  input  logic [1:0] in_tuser,   // [1:0] req_type
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] matched, [1] pattern_overflow, [7:2] zero
);
  import gwm_pkg::*;

  logic  item_v;
  item_t item;
  logic  fire;
  logic  res_v;
  res_t  res;

  // Advance the held word unless it is an end word facing a full result stage
  assign fire      = item_v && ((item.req != REQ_END) || !out_tvalid || out_tready);
  assign in_tready = !item_v || fire;

  gwm_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .fire      (fire),
    .item_v    (item_v),
    .item      (item)
  );

  gwm_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .res_v (res_v),
    .res   (res)
  );

  gwm_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_v      (res_v),
    .res        (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule
